// ===== design/fbpa_pkg.sv =====
package fbpa_pkg;

  localparam int ADDR_W = 4;

  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_SIZE  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_FULL   = 3'd1;
  localparam logic [2:0] STATUS_RANGE  = 3'd2;
  localparam logic [2:0] STATUS_ALIGN  = 3'd3;
  localparam logic [2:0] STATUS_DOUBLE = 3'd4;

  typedef struct packed {
    logic        func;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_address;
    logic [4:0]  slot_index;
    logic [5:0]  used_count;
  } rsp_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [12:0] element_size;
    logic [5:0]  slot_count;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RMUL,
    ST_RSUM,
    ST_RCHK,
    ST_DIV,
    ST_FREE,
    ST_DONE
  } state_t;

endpackage

// ===== design/fbpa_engine.sv =====
module fbpa_engine #(
  parameter int MAX_SLOTS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fbpa_pkg::req_t req,
  input  fbpa_pkg::cfg_t cfg,
  output logic          idle,
  output logic          res_valid,
  input  logic          res_take,
  output fbpa_pkg::rsp_t res
);

  localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int PROD_W = CNT_W + 13;
  localparam int OFS_W  = IDX_W + 13;
  localparam int DVS_W  = IDX_W + 12;
  localparam int STEP_W = $clog2(IDX_W + 1);

  fbpa_pkg::state_t state, state_next;

  logic [MAX_SLOTS-1:0] used, used_next;
  logic [5:0]           total, total_next;
  logic [31:0]          addr_r, addr_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic [31:0]          acc, acc_next;
  logic [PROD_W-1:0]    prod, prod_next;
  logic [32:0]          end_r, end_next;
  logic [OFS_W-1:0]     rem, rem_next;
  logic [DVS_W-1:0]     dvs, dvs_next;
  logic [IDX_W-1:0]     q, q_next;
  logic [STEP_W-1:0]    step, step_next;
  fbpa_pkg::rsp_t       res_r, res_next;

  logic [12:0]      size_eff;
  logic [CNT_W-1:0] cap;

  // Shared add/subtract unit; bit 33 is the borrow of a subtraction.
  logic [32:0] unit_a, unit_b;
  logic        unit_sub;
  logic [33:0] unit_res;
  logic        unit_borrow;

  assign size_eff = (cfg.element_size == 13'd0) ? 13'd1 : cfg.element_size;

  always_comb begin
    if (32'(cfg.slot_count) > 32'(MAX_SLOTS)) begin
      cap = CNT_W'(MAX_SLOTS);
    end else begin
      cap = CNT_W'(cfg.slot_count);
    end
  end

  assign unit_res = unit_sub ? ({1'b0, unit_a} - {1'b0, unit_b})
                             : ({1'b0, unit_a} + {1'b0, unit_b});
  assign unit_borrow = unit_res[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbpa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      total <= '0;
    end else begin
      used  <= used_next;
      total <= total_next;
    end
    addr_r <= addr_next;
    cnt    <= cnt_next;
    acc    <= acc_next;
    prod   <= prod_next;
    end_r  <= end_next;
    rem    <= rem_next;
    dvs    <= dvs_next;
    q      <= q_next;
    step   <= step_next;
    res_r  <= res_next;
  end

  always_comb begin
    state_next = state;
    used_next  = used;
    total_next = total;
    addr_next  = addr_r;
    cnt_next   = cnt;
    acc_next   = acc;
    prod_next  = prod;
    end_next   = end_r;
    rem_next   = rem;
    dvs_next   = dvs;
    q_next     = q;
    step_next  = step;
    res_next   = res_r;
    unit_a     = '0;
    unit_b     = '0;
    unit_sub   = 1'b0;

    case (state)
      fbpa_pkg::ST_IDLE: begin
        if (start) begin
          addr_next = req.address;
          cnt_next  = '0;
          acc_next  = cfg.base_address;
          if (req.func == fbpa_pkg::FUNC_ALLOC) begin
            state_next = fbpa_pkg::ST_SCAN;
          end else begin
            state_next = fbpa_pkg::ST_RMUL;
          end
        end
      end

      // One slot per cycle; acc tracks base plus slot times size.
      fbpa_pkg::ST_SCAN: begin
        unit_a = {1'b0, acc};
        unit_b = 33'(size_eff);
        res_next.block_address = '0;
        res_next.slot_index    = '0;
        res_next.used_count    = total;
        if (cnt == cap) begin
          res_next.status = fbpa_pkg::STATUS_FULL;
          state_next      = fbpa_pkg::ST_DONE;
        end else if (!used[cnt[IDX_W-1:0]]) begin
          used_next[cnt[IDX_W-1:0]] = 1'b1;
          total_next             = total + 6'd1;
          res_next.status        = fbpa_pkg::STATUS_OK;
          res_next.block_address = acc;
          res_next.slot_index    = 5'(cnt[IDX_W-1:0]);
          res_next.used_count    = total + 6'd1;
          state_next             = fbpa_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
          acc_next = unit_res[31:0];
        end
      end

      fbpa_pkg::ST_RMUL: begin
        prod_next  = PROD_W'(cap) * PROD_W'(size_eff);
        state_next = fbpa_pkg::ST_RSUM;
      end

      // Pool end is kept to 33 bits so that it never wraps.
      fbpa_pkg::ST_RSUM: begin
        unit_a     = {1'b0, cfg.base_address};
        unit_b     = 33'(prod);
        end_next   = unit_res[32:0];
        state_next = fbpa_pkg::ST_RCHK;
      end

      fbpa_pkg::ST_RCHK: begin
        unit_a   = {1'b0, addr_r};
        unit_b   = {1'b0, cfg.base_address};
        unit_sub = 1'b1;
        if (unit_borrow || ({1'b0, addr_r} >= end_r)) begin
          res_next.status        = fbpa_pkg::STATUS_RANGE;
          res_next.block_address = '0;
          res_next.slot_index    = '0;
          res_next.used_count    = total;
          state_next             = fbpa_pkg::ST_DONE;
        end else begin
          rem_next   = unit_res[OFS_W-1:0];
          dvs_next   = DVS_W'(size_eff) << (IDX_W - 1);
          q_next     = '0;
          step_next  = STEP_W'(IDX_W - 1);
          state_next = fbpa_pkg::ST_DIV;
        end
      end

      // Restoring division, one quotient bit per cycle. The offset is below
      // the pool span, so the quotient always fits the slot index.
      fbpa_pkg::ST_DIV: begin
        unit_a   = 33'(rem);
        unit_b   = 33'(dvs);
        unit_sub = 1'b1;
        if (!unit_borrow) begin
          rem_next = unit_res[OFS_W-1:0];
        end
        q_next   = (q << 1) | IDX_W'(!unit_borrow);
        dvs_next = dvs >> 1;
        if (step == '0) begin
          state_next = fbpa_pkg::ST_FREE;
        end else begin
          step_next = step - STEP_W'(1);
        end
      end

      fbpa_pkg::ST_FREE: begin
        res_next.block_address = '0;
        res_next.slot_index    = '0;
        res_next.used_count    = total;
        if (rem != '0) begin
          res_next.status = fbpa_pkg::STATUS_ALIGN;
        end else if (!used[q]) begin
          res_next.status = fbpa_pkg::STATUS_DOUBLE;
        end else begin
          used_next[q]           = 1'b0;
          total_next             = total - 6'd1;
          res_next.status        = fbpa_pkg::STATUS_OK;
          res_next.block_address = addr_r;
          res_next.slot_index    = 5'(q);
          res_next.used_count    = total - 6'd1;
        end
        state_next = fbpa_pkg::ST_DONE;
      end

      fbpa_pkg::ST_DONE: begin
        if (res_take) begin
          state_next = fbpa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fbpa_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle      = (state == fbpa_pkg::ST_IDLE);
  assign res_valid = (state == fbpa_pkg::ST_DONE);
  assign res       = res_r;

endmodule

// ===== design/fixed_block_pool_allocator_unit.sv =====
// Fixed-size block pool allocator.
// Requests arrive on req_valid/req_ready with req_data (func, address); one
// response per request leaves on rsp_valid/rsp_ready with rsp_data.
// An allocate request scans the usage bitmap one slot per cycle from slot 0
// and returns base plus slot times element size, or a full status when no
// active slot is free. A free request computes the pool end, checks the
// range, then divides the offset by the element size one quotient bit per
// cycle; an address out of range is answered after the range check, without
// the division. Adds and subtracts share one 33-bit unit, and one request is
// worked on at a time: req_ready is high only while the sequencer is idle.
// Responses sit in an output register, so a stalled receiver does not block
// the next request; the sequencer waits only when that register still holds
// an untaken response. The user must write base address, element size and
// slot count over the APB port only while no request is in flight; the block
// itself does not enforce this.
// Reset clears the bitmap and the used count, loads base 0, element size 1
// and slot count 32, and leaves the output empty.
module fixed_block_pool_allocator_unit #(
  parameter int MAX_SLOTS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  fbpa_pkg::req_t                req_data,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output fbpa_pkg::rsp_t                rsp_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbpa_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fbpa_pkg::cfg_t cfg;
  logic           cfg_wr;
  logic [1:0]     reg_idx;

  logic           eng_idle;
  logic           eng_valid;
  logic           out_take;
  fbpa_pkg::rsp_t eng_res;

  logic           rsp_valid_r;
  fbpa_pkg::rsp_t rsp_r;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= 32'd0;
      cfg.element_size <= 13'd1;
      cfg.slot_count   <= 6'd32;
    end else if (cfg_wr) begin
      case (reg_idx)
        fbpa_pkg::REG_BASE:  cfg.base_address <= pwdata;
        fbpa_pkg::REG_SIZE:  cfg.element_size <= pwdata[12:0];
        fbpa_pkg::REG_COUNT: cfg.slot_count   <= pwdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fbpa_pkg::REG_BASE:  prdata = cfg.base_address;
      fbpa_pkg::REG_SIZE:  prdata = 32'(cfg.element_size);
      fbpa_pkg::REG_COUNT: prdata = 32'(cfg.slot_count);
      default:             prdata = 32'd0;
    endcase
  end

  fbpa_engine #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (req_valid && req_ready),
    .req      (req_data),
    .cfg      (cfg),
    .idle     (eng_idle),
    .res_valid(eng_valid),
    .res_take (out_take),
    .res      (eng_res)
  );

  assign req_ready = eng_idle;
  assign out_take  = !rsp_valid_r || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_r <= 1'b0;
    end else if (eng_valid && out_take) begin
      rsp_valid_r <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_r <= 1'b0;
    end
    if (eng_valid && out_take) begin
      rsp_r <= eng_res;
    end
  end

  assign rsp_valid = rsp_valid_r;
  assign rsp_data  = rsp_r;

  // A failed request never reports an address or a slot.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != fbpa_pkg::STATUS_OK) |->
      (rsp_data.block_address == 32'd0) && (rsp_data.slot_index == 5'd0))
    else $error("error response carries an address or slot");

  // One request at a time: the sequencer leaves idle right after accepting.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while sequencer busy");

  a_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_data.status == fbpa_pkg::STATUS_OK) ||
                  (rsp_data.status == fbpa_pkg::STATUS_FULL) ||
                  (rsp_data.status == fbpa_pkg::STATUS_RANGE) ||
                  (rsp_data.status == fbpa_pkg::STATUS_ALIGN) ||
                  (rsp_data.status == fbpa_pkg::STATUS_DOUBLE))
    else $error("undefined status code");

  // A full pool hands out no slot.
  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    eng_valid && out_take && (eng_res.status == fbpa_pkg::STATUS_FULL) |->
      (eng_res.slot_index == 5'd0))
    else $error("full response carries a slot");

endmodule
